### sv/dar_pkg.sv
// shared constants, codes and types of the device address registry
`default_nettype none

package dar_pkg;

  // table size and derived widths
  localparam int unsigned ENTRIES     = 32;
  localparam int unsigned IDX_W       = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int unsigned CNT_W       = $clog2(ENTRIES + 1);
  localparam int unsigned MAX_RESULTS = 32;

  // field widths
  localparam int unsigned LIMIT_W = 6;
  localparam int unsigned SLOT_W  = 5;
  localparam int unsigned SHORT_W = 16;
  localparam int unsigned IEEE_W  = 64;
  localparam int unsigned CAP_W   = 8;
  localparam int unsigned SEEN_W  = 32;
  localparam int unsigned TS_W    = 63;

  typedef enum logic [0:0] {
    KIND_ANNOUNCE = 1'b0,
    KIND_SNAPSHOT = 1'b1
  } kind_e;

  typedef enum logic [1:0] {
    STATUS_UPDATED  = 2'd0,
    STATUS_NEW      = 2'd1,
    STATUS_FULL     = 2'd2,
    STATUS_SNAPSHOT = 2'd3
  } status_e;

  // one queued request
  typedef struct packed {
    kind_e               kind;
    logic [SHORT_W-1:0]  nwk_addr;
    logic [IEEE_W-1:0]   ext_addr;
    logic [CAP_W-1:0]    capability;
    logic [TS_W-1:0]     timestamp;
    logic [LIMIT_W-1:0]  limit;
  } cmd_t;

  // one table entry as stored in the ram
  typedef struct packed {
    logic [SHORT_W-1:0] nwk_addr;
    logic [IEEE_W-1:0]  ext_addr;
    logic [CAP_W-1:0]   capability;
    logic [SEEN_W-1:0]  seen;
    logic [TS_W-1:0]    last_seen;
  } entry_t;

  // one result
  typedef struct packed {
    status_e             status;
    logic [SLOT_W-1:0]   slot;
    logic                nwk_moved;
    logic [SHORT_W-1:0]  old_nwk;
    logic                entry_valid;
    entry_t              entry;
    logic                last;
  } res_t;

endpackage

`default_nettype wire

### sv/dar_ram.sv
// generic single-port-write, single-port-read ram with registered read
`default_nettype none

module dar_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 32,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AddrW-1:0] waddr_i,
  input  wire logic [Width-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AddrW-1:0] raddr_i,
  output logic      [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

### sv/dar_front.sv
// front end: takes requests, clamps the snapshot limit, two-deep request queue
`default_nettype none

module dar_front (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         push_i,
  output logic                              full_o,
  input  wire logic                         kind_i,
  input  wire logic [15:0]                  nwk_addr_i,
  input  wire logic [63:0]                  ext_addr_i,
  input  wire logic [7:0]                   capability_i,
  input  wire logic [62:0]                  timestamp_i,
  input  wire logic [5:0]                   snapshot_limit_i,
  output dar_pkg::cmd_t                     cmd_o,
  output logic                              cmd_valid_o,
  input  wire logic                         cmd_pop_i
);

  import dar_pkg::*;

  cmd_t       q_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] cnt_q, cnt_d;
  logic       do_push, do_pop;
  cmd_t       cmd_in;

  // classify and normalize
  always_comb begin
    cmd_in            = '0;
    cmd_in.kind       = kind_e'(kind_i);
    cmd_in.nwk_addr   = nwk_addr_i;
    cmd_in.ext_addr   = ext_addr_i;
    cmd_in.capability = capability_i;
    cmd_in.timestamp  = timestamp_i;
    cmd_in.limit      = (snapshot_limit_i > LIMIT_W'(MAX_RESULTS)) ?
                        LIMIT_W'(MAX_RESULTS) : snapshot_limit_i;
  end

  assign full_o      = (cnt_q == 2'd2);
  assign cmd_valid_o = (cnt_q != 2'd0);
  assign cmd_o       = q_q[rd_ptr_q];
  assign do_push     = push_i && !full_o;
  assign do_pop      = cmd_pop_i && cmd_valid_o;

  always_comb begin
    wr_ptr_d = do_push ? !wr_ptr_q : wr_ptr_q;
    rd_ptr_d = do_pop ? !rd_ptr_q : rd_ptr_q;
    cnt_d    = cnt_q + 2'(do_push) - 2'(do_pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      q_q[wr_ptr_q] <= cmd_in;
    end
  end

endmodule

`default_nettype wire

### sv/dar_back.sv
// back end: table ram, scan sequencer and two-deep result queue
`default_nettype none

module dar_back (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  dar_pkg::cmd_t      cmd_i,
  input  wire logic          cmd_valid_i,
  output logic               cmd_pop_o,
  output dar_pkg::res_t      res_o,
  output logic               empty_o,
  input  wire logic          pop_i
);

  import dar_pkg::*;

  localparam int unsigned CMP_W = (CNT_W > LIMIT_W) ? CNT_W : LIMIT_W;

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_READ   = 5'b00010,
    S_CHECK  = 5'b00100,
    S_COMMIT = 5'b01000,
    S_EMPTY  = 5'b10000
  } state_e;

  state_e             state_q, state_d;
  logic [CNT_W-1:0]   idx_q, idx_d;
  logic [CNT_W-1:0]   fill_q, fill_d;
  logic [CNT_W-1:0]   total_q, total_d;
  logic               short_hit_q, short_hit_d;
  logic               ieee_hit_q, ieee_hit_d;
  logic [IDX_W-1:0]   hit_idx_q, hit_idx_d;
  logic [SHORT_W-1:0] hit_short_q, hit_short_d;
  logic [SEEN_W-1:0]  hit_seen_q, hit_seen_d;

  logic               ram_we, ram_re;
  logic [IDX_W-1:0]   ram_waddr;
  entry_t             ram_wdata, ram_rdata;

  logic [CNT_W-1:0]   idx_nx;
  logic [CNT_W-1:0]   snap_total;
  logic               found, room;

  // result queue
  res_t       oq_q [2];
  logic       owr_q, ord_q;
  logic [1:0] ocnt_q;
  logic       ofull, opush, opop;
  res_t       ores;

  dar_ram #(
    .Width ($bits(entry_t)),
    .Depth (ENTRIES)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (idx_q[IDX_W-1:0]),
    .rdata_o (ram_rdata)
  );

  assign idx_nx     = idx_q + CNT_W'(1);
  assign snap_total = (CMP_W'(cmd_i.limit) < CMP_W'(fill_q)) ? CNT_W'(cmd_i.limit) : fill_q;
  assign found      = short_hit_q || ieee_hit_q;
  assign room       = (fill_q != CNT_W'(ENTRIES));
  assign ofull      = (ocnt_q == 2'd2);

  always_comb begin
    state_d     = state_q;
    idx_d       = idx_q;
    fill_d      = fill_q;
    total_d     = total_q;
    short_hit_d = short_hit_q;
    ieee_hit_d  = ieee_hit_q;
    hit_idx_d   = hit_idx_q;
    hit_short_d = hit_short_q;
    hit_seen_d  = hit_seen_q;
    ram_we      = 1'b0;
    ram_re      = 1'b0;
    ram_waddr   = hit_idx_q;
    ram_wdata   = '0;
    cmd_pop_o   = 1'b0;
    opush       = 1'b0;
    ores        = '0;

    case (state_q)
      S_IDLE: begin
        if (cmd_valid_i) begin
          idx_d       = '0;
          short_hit_d = 1'b0;
          ieee_hit_d  = 1'b0;
          if (cmd_i.kind == KIND_ANNOUNCE) begin
            state_d = (fill_q == '0) ? S_COMMIT : S_READ;
          end else begin
            total_d = snap_total;
            state_d = (snap_total == '0) ? S_EMPTY : S_READ;
          end
        end
      end

      S_READ: begin
        ram_re  = 1'b1;
        state_d = S_CHECK;
      end

      S_CHECK: begin
        if (cmd_i.kind == KIND_ANNOUNCE) begin
          // short address match wins at once, else remember first long match
          if (ram_rdata.nwk_addr == cmd_i.nwk_addr) begin
            short_hit_d = 1'b1;
            hit_idx_d   = idx_q[IDX_W-1:0];
            hit_short_d = ram_rdata.nwk_addr;
            hit_seen_d  = ram_rdata.seen;
            state_d     = S_COMMIT;
          end else begin
            if (!ieee_hit_q && (ram_rdata.ext_addr == cmd_i.ext_addr)) begin
              ieee_hit_d  = 1'b1;
              hit_idx_d   = idx_q[IDX_W-1:0];
              hit_short_d = ram_rdata.nwk_addr;
              hit_seen_d  = ram_rdata.seen;
            end
            if (idx_nx == fill_q) begin
              state_d = S_COMMIT;
            end else begin
              idx_d   = idx_nx;
              state_d = S_READ;
            end
          end
        end else if (!ofull) begin
          opush            = 1'b1;
          ores.status      = STATUS_SNAPSHOT;
          ores.slot        = SLOT_W'(idx_q);
          ores.entry_valid = 1'b1;
          ores.entry       = ram_rdata;
          ores.last        = (idx_nx == total_q);
          if (idx_nx == total_q) begin
            cmd_pop_o = 1'b1;
            state_d   = S_IDLE;
          end else begin
            idx_d   = idx_nx;
            state_d = S_READ;
          end
        end
      end

      S_COMMIT: begin
        ram_wdata.nwk_addr   = cmd_i.nwk_addr;
        ram_wdata.ext_addr   = cmd_i.ext_addr;
        ram_wdata.capability = cmd_i.capability;
        ram_wdata.last_seen  = cmd_i.timestamp;
        ores.last            = 1'b1;
        if (found) begin
          ram_wdata.seen = hit_seen_q + SEEN_W'(1);
          ores.status    = STATUS_UPDATED;
          ores.slot      = SLOT_W'(hit_idx_q);
          ores.old_nwk   = hit_short_q;
          ores.nwk_moved = (hit_short_q != cmd_i.nwk_addr);
        end else if (room) begin
          ram_waddr      = fill_q[IDX_W-1:0];
          ram_wdata.seen = SEEN_W'(1);
          ores.status    = STATUS_NEW;
          ores.slot      = SLOT_W'(fill_q);
        end else begin
          ores.status = STATUS_FULL;
        end
        if (!ofull) begin
          opush     = 1'b1;
          ram_we    = found || room;
          cmd_pop_o = 1'b1;
          state_d   = S_IDLE;
          if (!found && room) begin
            fill_d = fill_q + CNT_W'(1);
          end
        end
      end

      S_EMPTY: begin
        ores.status = STATUS_SNAPSHOT;
        ores.last   = 1'b1;
        if (!ofull) begin
          opush     = 1'b1;
          cmd_pop_o = 1'b1;
          state_d   = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      idx_q       <= '0;
      fill_q      <= '0;
      total_q     <= '0;
      short_hit_q <= 1'b0;
      ieee_hit_q  <= 1'b0;
    end else begin
      state_q     <= state_d;
      idx_q       <= idx_d;
      fill_q      <= fill_d;
      total_q     <= total_d;
      short_hit_q <= short_hit_d;
      ieee_hit_q  <= ieee_hit_d;
    end
  end

  always_ff @(posedge clk_i) begin
    hit_idx_q   <= hit_idx_d;
    hit_short_q <= hit_short_d;
    hit_seen_q  <= hit_seen_d;
  end

  // result queue
  assign empty_o = (ocnt_q == 2'd0);
  assign res_o   = oq_q[ord_q];
  assign opop    = pop_i && !empty_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      owr_q  <= 1'b0;
      ord_q  <= 1'b0;
      ocnt_q <= 2'd0;
    end else begin
      if (opush) begin
        owr_q <= !owr_q;
      end
      if (opop) begin
        ord_q <= !ord_q;
      end
      ocnt_q <= ocnt_q + 2'(opush) - 2'(opop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (opush) begin
      oq_q[owr_q] <= ores;
    end
  end

endmodule

`default_nettype wire

### sv/device_address_registry.sv
// top level of the device address registry
//
//  channel   | handshake   | payload
//  ----------+-------------+--------------------------------------------------------------
//  request   | push / full | kind, nwk_addr, ext_addr, capability, timestamp, snapshot_limit
//  result    | empty / pop | status, slot, nwk_moved, old_nwk, entry_valid, entry_*, last
//
// an announce reads slots in order up to and including a short address match, at most the
// fill count, then gives its single result
// a snapshot gives one result per emitted entry, an empty one a single result with no entry
// reset clears the fill count and control; ram contents need no clearing pass
// since only slots below the fill count are ever read
// a full result queue stalls the back end; the front queue keeps taking two requests
`default_nettype none

module device_address_registry (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  // request side
  input  wire logic         push,
  output logic              full,
  input  wire logic         kind_i,
  input  wire logic [15:0]  nwk_addr_i,
  input  wire logic [63:0]  ext_addr_i,
  input  wire logic [7:0]   capability_i,
  input  wire logic [62:0]  timestamp_i,
  input  wire logic [5:0]   snapshot_limit_i,
  // result side
  output logic              empty,
  input  wire logic         pop,
  output logic [1:0]        status_o,
  output logic [4:0]        slot_o,
  output logic              nwk_moved_o,
  output logic [15:0]       old_nwk_o,
  output logic              entry_valid_o,
  output logic [15:0]       entry_short_o,
  output logic [63:0]       entry_ieee_o,
  output logic [7:0]        entry_capability_o,
  output logic [31:0]       entry_seen_o,
  output logic [62:0]       entry_last_seen_o,
  output logic              last_o
);

  import dar_pkg::*;

  cmd_t cmd;
  logic cmd_valid;
  logic cmd_pop;
  res_t res;

  // front end: request queue
  dar_front u_front (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .push_i           (push),
    .full_o           (full),
    .kind_i           (kind_i),
    .nwk_addr_i       (nwk_addr_i),
    .ext_addr_i       (ext_addr_i),
    .capability_i     (capability_i),
    .timestamp_i      (timestamp_i),
    .snapshot_limit_i (snapshot_limit_i),
    .cmd_o            (cmd),
    .cmd_valid_o      (cmd_valid),
    .cmd_pop_i        (cmd_pop)
  );

  // back end: table, sequencer, result queue
  dar_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .cmd_valid_i (cmd_valid),
    .cmd_pop_o   (cmd_pop),
    .res_o       (res),
    .empty_o     (empty),
    .pop_i       (pop)
  );

  // unpack the head result onto the ports
  assign status_o           = res.status;
  assign slot_o             = res.slot;
  assign nwk_moved_o        = res.nwk_moved;
  assign old_nwk_o          = res.old_nwk;
  assign entry_valid_o      = res.entry_valid;
  assign entry_short_o      = res.entry.nwk_addr;
  assign entry_ieee_o       = res.entry.ext_addr;
  assign entry_capability_o = res.entry.capability;
  assign entry_seen_o       = res.entry.seen;
  assign entry_last_seen_o  = res.entry.last_seen;
  assign last_o             = res.last;

endmodule

`default_nettype wire

### sv/dar_checker.sv
// port-level checker for the device address registry and its bind
`default_nettype none

module dar_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        empty,
  input wire logic        pop,
  input wire logic [1:0]  status_o,
  input wire logic [4:0]  slot_o,
  input wire logic        nwk_moved_o,
  input wire logic [15:0] old_nwk_o,
  input wire logic        entry_valid_o,
  input wire logic [63:0] entry_ieee_o,
  input wire logic [31:0] entry_seen_o,
  input wire logic        last_o
);

  import dar_pkg::*;

  // a waiting result holds until taken
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> (!empty && $stable(status_o) && $stable(slot_o) &&
                          $stable(entry_ieee_o) && $stable(last_o)))
    else $error("waiting result changed before pop");

  // an announce gives exactly one result
  a_ann_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && (status_o != STATUS_SNAPSHOT)) |-> (last_o && !entry_valid_o))
    else $error("announce result not single or carries an entry");

  // only snapshot results carry entries, and those have been seen
  a_entry: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && entry_valid_o) |->
      ((status_o == STATUS_SNAPSHOT) && (entry_seen_o != 32'd0)))
    else $error("entry result with bad status or zero count");

  // fresh slots and drops report no previous short address
  a_fresh: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && ((status_o == STATUS_NEW) || (status_o == STATUS_FULL))) |->
      (!nwk_moved_o && (old_nwk_o == 16'd0)))
    else $error("new or dropped result reports a previous short address");

endmodule

bind device_address_registry dar_checker u_dar_checker (.*);

`default_nettype wire
